### design/rla_pkg.sv
// Package for the running LCM accumulator: word types, widths, sequencer states.
// No dependencies; used by running_lcm_accumulator.
package rla_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);

    localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {VALUE_WIDTH{1'b1}};
    localparam logic [VALUE_WIDTH-1:0] VALUE_ONE = {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
    localparam logic [CNT_W-1:0]       CNT_LAST  = CNT_W'(VALUE_WIDTH - 1);

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   first;
    } t_in_word;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] lcm;
        logic                   overflow;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVEN,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } t_state;

endpackage

### design/running_lcm_accumulator.sv
// Running LCM accumulator: binary gcd, restoring divide and shift-add multiply
// on one shared add/subtract unit. Depends on rla_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one word: a
//   positive value and a first flag that restarts the run from 1. Output
//   channel (o_out_valid / i_out_stall / o_out_data) gives one word per input:
//   the running LCM, saturated at all ones, and the sticky overflow flag.
//   A value of zero leaves the run as it is and just reports it.
//   One word is in work at a time; o_in_stall is high from acceptance until
//   the result is loaded into the output register.
//   A zero value or an already saturated run goes straight to the result.
//   Otherwise common factors of two are stripped first; then the binary gcd
//   loop (shift, subtract or swap), the W-step divide and the W-step multiply,
//   where W = VALUE_WIDTH (31), all run one step a cycle on the single adder.
//   The output register lets the next word be accepted while a result waits;
//   a stalled result holds, and the sequencer waits in its final state until
//   the output register frees up.
//   Reset (i_rst_n low, synchronous) sets the run to 1, clears overflow and
//   drops any word in progress or pending.
module running_lcm_accumulator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rla_pkg::t_in_word i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rla_pkg::t_out_word o_out_data
);

    localparam int W = rla_pkg::VALUE_WIDTH;

    rla_pkg::t_state r_state, n_state;

    logic [W-1:0]             r_a, n_a;     // gcd operand, then divisor
    logic [W-1:0]             r_b, n_b;     // gcd operand, remainder, product
    logic [W-1:0]             r_n, n_n;     // numerator / quotient shift reg
    logic [W-1:0]             r_v, n_v;
    logic [rla_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                     r_povf, n_povf;
    logic [W-1:0]             r_lcm, n_lcm;
    logic                     r_ovf, n_ovf;
    logic                     r_out_valid, n_out_valid;
    rla_pkg::t_out_word       r_out, n_out;

    logic [W+1:0] alu_x, alu_y, alu_sum;
    logic         alu_sub;
    logic         borrow;
    logic         prod_big;
    logic         mul_ovf;
    logic [W-1:0] in_acc;
    logic         in_ovf;
    logic         q_bit;

    assign in_acc = i_in_data.first ? rla_pkg::VALUE_ONE : r_lcm;
    assign in_ovf = i_in_data.first ? 1'b0 : r_ovf;

    // shared adder operand select
    always_comb begin
        alu_x   = '0;
        alu_y   = '0;
        alu_sub = 1'b0;
        case (r_state)
            rla_pkg::ST_GCD: begin
                alu_x   = {2'b00, r_a};
                alu_y   = {2'b00, r_b};
                alu_sub = 1'b1;
            end
            rla_pkg::ST_DIV: begin
                alu_x   = {1'b0, r_b, r_n[W-1]};
                alu_y   = {2'b00, r_a};
                alu_sub = 1'b1;
            end
            rla_pkg::ST_MUL: begin
                alu_x   = {1'b0, r_b, 1'b0};
                alu_y   = r_n[W-1] ? {2'b00, r_v} : '0;
                alu_sub = 1'b0;
            end
            default: begin
                alu_x   = '0;
                alu_y   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_sum  = alu_x + (alu_sub ? ~alu_y : alu_y) + {{(W+1){1'b0}}, alu_sub};
    assign borrow   = alu_sum[W+1];
    assign prod_big = (alu_sum[W+1:W] != 2'b00);
    assign mul_ovf  = r_povf | prod_big;
    assign q_bit    = ~borrow;

    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_n         = r_n;
        n_v         = r_v;
        n_cnt       = r_cnt;
        n_povf      = r_povf;
        n_lcm       = r_lcm;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            rla_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_lcm = in_acc;
                    n_ovf = in_ovf;
                    if (i_in_data.value == '0 || in_ovf) begin
                        n_state = rla_pkg::ST_DONE;
                    end else begin
                        n_a     = in_acc;
                        n_b     = i_in_data.value;
                        n_n     = in_acc;
                        n_v     = i_in_data.value;
                        n_state = rla_pkg::ST_EVEN;
                    end
                end
            end
            rla_pkg::ST_EVEN: begin
                // strip common factors of two; keep numerator divided alongside
                if (!r_a[0] && !r_b[0]) begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_n = r_n >> 1;
                end else begin
                    n_state = rla_pkg::ST_GCD;
                end
            end
            rla_pkg::ST_GCD: begin
                if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (alu_sum == '0) begin
                    // r_a holds the odd part of the gcd: divide by it next
                    n_b     = '0;
                    n_cnt   = rla_pkg::CNT_LAST;
                    n_state = rla_pkg::ST_DIV;
                end else if (borrow) begin
                    n_a = r_b;
                    n_b = r_a;
                end else begin
                    n_a = alu_sum[W-1:0];
                end
            end
            rla_pkg::ST_DIV: begin
                if (q_bit) begin
                    n_b = alu_sum[W-1:0];
                end else begin
                    n_b = {r_b[W-2:0], r_n[W-1]};
                end
                n_n = {r_n[W-2:0], q_bit};
                if (r_cnt == '0) begin
                    n_b     = '0;
                    n_povf  = 1'b0;
                    n_cnt   = rla_pkg::CNT_LAST;
                    n_state = rla_pkg::ST_MUL;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            rla_pkg::ST_MUL: begin
                // quotient MSB first; hold the partial product once it saturates
                n_n = {r_n[W-2:0], 1'b0};
                if (!mul_ovf) begin
                    n_b = alu_sum[W-1:0];
                end
                n_povf = mul_ovf;
                if (r_cnt == '0) begin
                    n_lcm   = mul_ovf ? rla_pkg::VALUE_MAX : alu_sum[W-1:0];
                    n_ovf   = mul_ovf;
                    n_state = rla_pkg::ST_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            rla_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid    = 1'b1;
                    n_out.lcm      = r_lcm;
                    n_out.overflow = r_ovf;
                    n_state        = rla_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rla_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rla_pkg::ST_IDLE;
            r_lcm       <= rla_pkg::VALUE_ONE;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lcm       <= n_lcm;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_n    <= n_n;
        r_v    <= n_v;
        r_cnt  <= n_cnt;
        r_povf <= n_povf;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != rla_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_lcm_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lcm != '0)
        else $error("running lcm went to zero");

    a_ovf_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_lcm == rla_pkg::VALUE_MAX))
        else $error("overflow set without saturated lcm");

    a_gcd_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rla_pkg::ST_GCD) |-> (r_a != '0 && r_b != '0))
        else $error("gcd operand reached zero");

    a_div_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rla_pkg::ST_DIV) |-> r_a[0])
        else $error("divisor is not the odd gcd part");

    a_done_from_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rla_pkg::ST_MUL && r_cnt == '0) |=> (r_state == rla_pkg::ST_DONE))
        else $error("multiply did not finish into done");

endmodule

### tb/sv/rla_lcm_checker.sv
`timescale 1ns / 100ps
// Checker for running_lcm_accumulator: watches both word channels, predicts the
// running LCM and overflow flag of each accepted input word and compares results.
// Depends on rla_pkg.
module rla_lcm_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  rla_pkg::t_in_word  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  rla_pkg::t_out_word i_out_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_saturated
);

    localparam int REPORT_LIMIT = 10;

    // predicted run state
    logic [rla_pkg::VALUE_WIDTH-1:0] run_lcm = rla_pkg::VALUE_ONE;
    logic                            run_ovf = 1'b0;

    rla_pkg::t_out_word lcm_expected_q[$];

    int fail_total      = 0;
    int checked_total   = 0;
    int saturated_total = 0;

    task automatic note_mismatch(input string msg);
        fail_total++;
        if (fail_total <= REPORT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin : watch
        rla_pkg::t_out_word want;
        rla_pkg::t_out_word got;
        logic [63:0]        acc;
        logic [63:0]        val;
        logic [63:0]        rem;
        logic [63:0]        div;
        logic [63:0]        prod;

        if (!i_rst_n) begin
            run_lcm = rla_pkg::VALUE_ONE;
            run_ovf = 1'b0;
            lcm_expected_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (lcm_expected_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected result lcm=%0d overflow=%0b",
                                            got.lcm, got.overflow));
                end else begin
                    want = lcm_expected_q.pop_front();
                    checked_total++;
                    if (got.overflow)
                        saturated_total++;
                    if (got.lcm !== want.lcm)
                        note_mismatch($sformatf("lcm expected %0d, got %0d",
                                                want.lcm, got.lcm));
                    if (got.overflow !== want.overflow)
                        note_mismatch($sformatf("overflow expected %0b, got %0b (lcm %0d)",
                                                want.overflow, got.overflow, want.lcm));
                end
            end

            if (i_in_valid && !i_in_stall) begin
                val = 64'(i_in_data.value);
                if (i_in_data.first) begin
                    run_lcm = rla_pkg::VALUE_ONE;
                    run_ovf = 1'b0;
                end
                // a zero value or a saturated run leaves the accumulator alone
                if (val != 0 && !run_ovf) begin
                    acc = 64'(run_lcm);
                    div = val;
                    prod = acc;
                    while (div != 0) begin
                        rem  = prod % div;
                        prod = div;
                        div  = rem;
                    end
                    prod = (acc / prod) * val;
                    if (prod > 64'(rla_pkg::VALUE_MAX)) begin
                        run_lcm = rla_pkg::VALUE_MAX;
                        run_ovf = 1'b1;
                    end else begin
                        run_lcm = prod[rla_pkg::VALUE_WIDTH-1:0];
                    end
                end
                want.lcm      = run_lcm;
                want.overflow = run_ovf;
                lcm_expected_q.insert(lcm_expected_q.size(), want);
            end
        end

        o_pending    <= lcm_expected_q.size();
        o_fail_count <= fail_total;
        o_checked    <= checked_total;
        o_saturated  <= saturated_total;
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the running_lcm_accumulator testbench: clock, reset, word stimulus,
// output stall pattern, watchdog and verdict. Depends on rla_pkg, rla_lcm_checker.
module tb_top;

    localparam int RANDOM_WORDS     = 530;
    localparam int CALM_WORDS       = 110;
    localparam int HOLD_WORDS       = 12;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT   = 6000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               out_stall = 1'b0;
    rla_pkg::t_in_word  in_data   = '0;
    logic               in_stall;
    logic               out_valid;
    rla_pkg::t_out_word out_data;

    int fail_count;
    int pending;
    int checked;
    int saturated;

    logic src_jitter  = 1'b0;
    logic sink_jitter = 1'b0;
    int   hold_asked  = 0;
    int   hold_served = 0;
    int   hold_left   = 0;
    int   words_sent  = 0;
    int   runs_sent   = 0;

    running_lcm_accumulator u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    rla_lcm_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_saturated  (saturated)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, or a long hold-off when one is asked for
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_served + 1;
            hold_left   <= SINK_HOLD_CYCLES;
            out_stall   <= 1'b1;
        end else begin
            out_stall <= sink_jitter && ($urandom_range(0, 99) < 29);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending);
        $display("tb: failure");
        $finish;
    end

    function automatic rla_pkg::t_in_word mk_word(input logic [rla_pkg::VALUE_WIDTH-1:0] v,
                                                  input logic f);
        rla_pkg::t_in_word w;
        w.value = v;
        w.first = f;
        return w;
    endfunction

    function automatic logic [rla_pkg::VALUE_WIDTH-1:0] pick_value();
        logic [rla_pkg::VALUE_WIDTH-1:0] v;
        case ($urandom_range(0, 15))
            0:          v = '0;
            1, 2, 3, 4: v = rla_pkg::VALUE_WIDTH'($urandom_range(1, 24));
            5, 6, 7:    v = rla_pkg::VALUE_WIDTH'($urandom_range(1, 255) << $urandom_range(0, 20));
            8, 9:       v = rla_pkg::VALUE_WIDTH'($urandom_range(1, 4095));
            10:         v = rla_pkg::VALUE_WIDTH'($urandom_range(1, 65535));
            11, 12, 13: v = rla_pkg::VALUE_WIDTH'($urandom);
            14:         v = rla_pkg::VALUE_MAX - rla_pkg::VALUE_WIDTH'($urandom_range(0, 3));
            default:    v = rla_pkg::VALUE_WIDTH'(1) << $urandom_range(0, rla_pkg::VALUE_WIDTH - 1);
        endcase
        return v;
    endfunction

    task automatic send_word(input rla_pkg::t_in_word w);
        while (src_jitter && $urandom_range(0, 99) < 29) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    // one run: restart, then a random number of words, with a little noise
    task automatic send_run();
        int len;
        logic f;
        len = $urandom_range(1, 10);
        runs_sent++;
        for (int i = 0; i < len; i++) begin
            f = (i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 19) == 0);
            send_word(mk_word(pick_value(), f));
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words, no idling on either side
        send_word(mk_word(31'd1, 1'b1));
        send_word(mk_word(rla_pkg::VALUE_MAX, 1'b0));   // exactly at the top, no overflow
        send_word(mk_word(rla_pkg::VALUE_MAX, 1'b0));
        send_word(mk_word(31'd2, 1'b0));                // overflow
        send_word(mk_word(31'd3, 1'b0));                // saturated run holds
        send_word(mk_word(31'd0, 1'b0));
        send_word(mk_word(31'd0, 1'b1));                // restart with zero value
        send_word(mk_word(31'd12, 1'b0));
        send_word(mk_word(31'd18, 1'b0));
        send_word(mk_word(31'd36, 1'b0));
        send_word(mk_word(31'd0, 1'b0));
        send_word(mk_word(31'd7, 1'b0));
        send_word(mk_word(31'h4000_0000, 1'b1));
        send_word(mk_word(31'h4000_0000, 1'b0));
        send_word(mk_word(31'd3, 1'b0));
        send_word(mk_word(31'd46341, 1'b1));
        send_word(mk_word(31'd46340, 1'b0));
        send_word(mk_word(31'd65536, 1'b1));
        send_word(mk_word(31'd32768, 1'b0));
        send_word(mk_word(31'd65535, 1'b0));
        send_word(mk_word(31'd2147483629, 1'b1));
        send_word(mk_word(31'd2147483629, 1'b0));
        send_word(mk_word(31'd1, 1'b0));
        drain_results();

        src_jitter  = 1'b1;
        sink_jitter <= 1'b1;
        while (words_sent < 23 + RANDOM_WORDS / 3)
            send_run();

        // fill the block against a long output hold-off
        hold_asked <= hold_asked + 1;
        for (int i = 0; i < HOLD_WORDS; i++)
            send_word(mk_word(pick_value(), i == 0));
        drain_results();

        // long stretch without idling
        src_jitter  = 1'b0;
        sink_jitter <= 1'b0;
        while (words_sent < 23 + RANDOM_WORDS / 3 + HOLD_WORDS + CALM_WORDS)
            send_run();

        src_jitter  = 1'b1;
        sink_jitter <= 1'b1;
        while (words_sent < 23 + RANDOM_WORDS)
            send_run();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("summary: %0d words in %0d random runs plus directed cases,", words_sent,
                 runs_sent);
        $display("summary: %0d results checked, %0d saturated, %0d mismatches",
                 checked, saturated, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d results never arrived", pending);
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
design/rla_pkg.sv
design/running_lcm_accumulator.sv
tb/sv/rla_lcm_checker.sv
tb/sv/tb_top.sv
